@@ rtl/afpc_pkg.sv @@
// Shared types and constants for the alloc/free pair canceller.
// No dependencies; every other file imports this package.
package afpc_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int TAG_BITS_DEF    = 16;

    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 16;
    localparam int OTYPE_W = 32;

    // stream widths
    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;
    localparam int M_PAD_W   = 5;

    // event kinds
    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;

    // patch kinds
    localparam logic [1:0] PATCH_STACK_ONLY = 2'd0;
    localparam logic [1:0] PATCH_INVALID    = 2'd1;
    localparam logic [1:0] PATCH_TYPE       = 2'd2;

    // entry flag bits
    localparam int FLAG_ALLOC_POS = 0;
    localparam int FLAG_STACK_POS = 1;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic capture;  // latch compare results for the held event
        logic append;   // write the held alloc into the first free cell
        logic cancel;   // drop the selected entry, cells above shift down
    } afpc_ctl_t;

endpackage

@@ rtl/afpc_cell.sv @@
// One table entry of the pending-alloc chain: storage, address compare, priority link.
// Depends on afpc_pkg.
module afpc_cell #(
    parameter int TAG_BITS = afpc_pkg::TAG_BITS_DEF,
    parameter int CNT_W    = 9,
    parameter int INDEX    = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  afpc_pkg::afpc_ctl_t           ctl,
    input  logic [CNT_W-1:0]              count,
    input  logic                          search,
    input  logic                          item_update,
    input  logic                          item_dealloc,
    input  logic                          item_vm,
    input  logic [afpc_pkg::ADDR_W-1:0]   item_addr,
    input  logic [TAG_BITS-1:0]           item_tag,
    input  logic [1:0]                    item_flags,
    input  logic [afpc_pkg::ADDR_W-1:0]   up_addr,
    input  logic [TAG_BITS-1:0]           up_tag,
    input  logic [1:0]                    up_flags,
    input  logic                          above_in,
    output logic                          above_out,
    output logic [afpc_pkg::ADDR_W-1:0]   addr_out,
    output logic [TAG_BITS-1:0]           tag_out,
    output logic [1:0]                    flags_out,
    output logic [TAG_BITS-1:0]           sel_tag,
    output logic [1:0]                    sel_flags
);
    import afpc_pkg::*;

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    logic [ADDR_W-1:0]   addr_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [1:0]          flags_reg;
    logic                hit_reg;
    logic                hit_next;
    logic                occupied;
    logic                sel;
    logic                take_up;
    logic                take_item;

    assign occupied = count > MY_INDEX;

    // alloc-flagged entries answer deallocs and updates, others only vm deallocs
    always_comb
    begin
        hit_next = occupied & search & (addr_reg == item_addr) &
                   (flags_reg[FLAG_ALLOC_POS] ? (item_dealloc | item_update) : item_vm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            hit_reg <= hit_next;
        end
    end

    // newest hit wins: nothing above may have hit
    assign sel       = hit_reg & ~above_in;
    assign above_out = above_in | hit_reg;
    assign take_up   = ctl.cancel & ~above_in;
    assign take_item = ctl.append & (count == MY_INDEX);

    always_ff @(posedge clk)
    begin
        if (take_up)
        begin
            addr_reg  <= up_addr;
            tag_reg   <= up_tag;
            flags_reg <= up_flags;
        end
        else if (take_item)
        begin
            addr_reg  <= item_addr;
            tag_reg   <= item_tag;
            flags_reg <= item_flags;
        end
    end

    assign addr_out  = addr_reg;
    assign tag_out   = tag_reg;
    assign flags_out = flags_reg;
    assign sel_tag   = sel ? tag_reg : '0;
    assign sel_flags = sel ? flags_reg : 2'b00;

endmodule

@@ rtl/afpc_cell_row.sv @@
// Row of afpc_cell entries, oldest at index 0; collects the selected entry.
// Depends on afpc_pkg and afpc_cell.
module afpc_cell_row #(
    parameter int TABLE_DEPTH = afpc_pkg::TABLE_DEPTH_DEF,
    parameter int TAG_BITS    = afpc_pkg::TAG_BITS_DEF,
    parameter int CNT_W       = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  afpc_pkg::afpc_ctl_t           ctl,
    input  logic [CNT_W-1:0]              count,
    input  logic                          search,
    input  logic                          item_update,
    input  logic                          item_dealloc,
    input  logic                          item_vm,
    input  logic [afpc_pkg::ADDR_W-1:0]   item_addr,
    input  logic [TAG_BITS-1:0]           item_tag,
    input  logic [1:0]                    item_flags,
    output logic                          found,
    output logic [TAG_BITS-1:0]           found_tag,
    output logic [1:0]                    found_flags
);
    import afpc_pkg::*;

    logic [ADDR_W-1:0]   addr_c  [TABLE_DEPTH+1];
    logic [TAG_BITS-1:0] tag_c   [TABLE_DEPTH+1];
    logic [1:0]          flags_c [TABLE_DEPTH+1];
    logic                above_c [TABLE_DEPTH+1];
    logic [TAG_BITS-1:0] sel_tag_c   [TABLE_DEPTH];
    logic [1:0]          sel_flags_c [TABLE_DEPTH];

    // nothing above the top cell
    assign addr_c[TABLE_DEPTH]  = '0;
    assign tag_c[TABLE_DEPTH]   = '0;
    assign flags_c[TABLE_DEPTH] = 2'b00;
    assign above_c[TABLE_DEPTH] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        afpc_cell #(
            .TAG_BITS (TAG_BITS),
            .CNT_W    (CNT_W),
            .INDEX    (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .count        (count),
            .search       (search),
            .item_update  (item_update),
            .item_dealloc (item_dealloc),
            .item_vm      (item_vm),
            .item_addr    (item_addr),
            .item_tag     (item_tag),
            .item_flags   (item_flags),
            .up_addr      (addr_c[i+1]),
            .up_tag       (tag_c[i+1]),
            .up_flags     (flags_c[i+1]),
            .above_in     (above_c[i+1]),
            .above_out    (above_c[i]),
            .addr_out     (addr_c[i]),
            .tag_out      (tag_c[i]),
            .flags_out    (flags_c[i]),
            .sel_tag      (sel_tag_c[i]),
            .sel_flags    (sel_flags_c[i])
        );
    end

    assign found = above_c[0];

    // at most one cell is selected, so an OR picks its contents
    always_comb
    begin
        found_tag   = '0;
        found_flags = 2'b00;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            found_tag   = found_tag | sel_tag_c[i];
            found_flags = found_flags | sel_flags_c[i];
        end
    end

endmodule

@@ rtl/alloc_free_pair_canceller.sv @@
// Top level of the alloc/free pair canceller: stream ports, control and result register.
// Depends on afpc_pkg and afpc_cell_row.
//
// Usage:
//   Trace events enter on the s_axis channel, one per transaction; tlast marks the
//   final event of a buffer, after which the pending table is emptied. Each event
//   yields exactly one result transaction on m_axis.
//   Alloc events are appended to a chain of TABLE_DEPTH cells, oldest in cell 0.
//   Other events compare their address against every cell in parallel; the newest
//   qualifying hit is chosen through a priority link that runs down the chain.
//   A cancelled entry leaves the chain as the cells above it shift down one place.
// Pipeline:
//   An accepted event passes through the parallel compare, whose hits are registered,
//   then through the priority pick and the chain update, which register the result.
//   A new event can be accepted while the one before is resolved, but not during its compare.
// Reset:
//   The table is empty (count zero); no clearing pass is needed.
// Back-pressure:
//   While a result waits on m_axis_tready the next event is still accepted and
//   compared; its resolve step then holds until the output register frees.
module alloc_free_pair_canceller #(
    parameter int TABLE_DEPTH = afpc_pkg::TABLE_DEPTH_DEF,
    parameter int TAG_BITS    = afpc_pkg::TAG_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // event_tag[15:0], address[79:16], has_stack[80], obj_type[112:81], zero pad
    input  logic [afpc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode[1:0], flag_alloc[2], flag_dealloc[3], flag_vm_dealloc[4]
    input  logic [afpc_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input  logic                             s_axis_tlast,     // last_in_buffer
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // current_kept[0], patch_valid[1], patch_tag[17:2], patch_obj_type[49:18],
    // table_overflow[50], zero pad
    output logic [afpc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // patch_kind[1:0]
    output logic [afpc_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
    import afpc_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RESOLVE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // held event
    logic [1:0]          item_mode_reg;
    logic [TAG_BITS-1:0] item_tag_reg;
    logic [ADDR_W-1:0]   item_addr_reg;
    logic                item_alloc_reg;
    logic                item_dealloc_reg;
    logic                item_vm_reg;
    logic                item_stack_reg;
    logic [OTYPE_W-1:0]  item_otype_reg;
    logic                item_last_reg;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg;
    logic [M_TUSER_W-1:0] m_user_next;

    logic                out_free;
    logic                accept;
    logic                resolve_go;
    logic                is_alloc;
    logic                is_update;
    logic                full;
    logic                found;
    logic [TAG_BITS-1:0] found_tag;
    logic [1:0]          found_flags;
    logic                cancel;
    logic                patch_type;
    logic                overflow;
    logic [TAG_W-1:0]    patch_tag;
    logic [1:0]          patch_kind;
    logic [OTYPE_W-1:0]  patch_otype;
    logic [1:0]          item_flags;
    afpc_ctl_t           ctl;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) || ((state_reg == ST_RESOLVE) && out_free);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign resolve_go    = (state_reg == ST_RESOLVE) && out_free;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_mode_reg    <= s_axis_tuser[1:0];
            item_alloc_reg   <= s_axis_tuser[2];
            item_dealloc_reg <= s_axis_tuser[3];
            item_vm_reg      <= s_axis_tuser[4];
            item_tag_reg     <= TAG_BITS'(s_axis_tdata[15:0]);
            item_addr_reg    <= s_axis_tdata[79:16];
            item_stack_reg   <= s_axis_tdata[80];
            item_otype_reg   <= s_axis_tdata[112:81];
            item_last_reg    <= s_axis_tlast;
        end
    end

    assign is_alloc   = item_mode_reg == MODE_ALLOC;
    assign is_update  = item_mode_reg == MODE_UPDATE;
    assign full       = count_reg == FULL_COUNT;
    assign item_flags = {item_stack_reg, item_alloc_reg};

    // a hit on an alloc entry by a non-dealloc can only be an update: type patch
    assign cancel     = found && (found_flags[FLAG_ALLOC_POS] ? item_dealloc_reg : 1'b1);
    assign patch_type = found && !cancel;
    assign overflow   = is_alloc && full;

    always_comb
    begin
        ctl.capture = state_reg == ST_LOOK;
        ctl.append  = resolve_go && is_alloc && !full;
        ctl.cancel  = resolve_go && cancel;
    end

    afpc_cell_row #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .CNT_W       (CNT_W)
    ) u_row (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .count        (count_reg),
        .search       (!is_alloc),
        .item_update  (is_update),
        .item_dealloc (item_dealloc_reg),
        .item_vm      (item_vm_reg),
        .item_addr    (item_addr_reg),
        .item_tag     (item_tag_reg),
        .item_flags   (item_flags),
        .found        (found),
        .found_tag    (found_tag),
        .found_flags  (found_flags)
    );

    always_comb
    begin
        patch_tag   = TAG_W'(found_tag);
        patch_otype = patch_type ? item_otype_reg : '0;
        if (cancel)
        begin
            patch_kind = found_flags[FLAG_STACK_POS] ? PATCH_STACK_ONLY : PATCH_INVALID;
        end
        else if (patch_type)
        begin
            patch_kind = PATCH_TYPE;
        end
        else
        begin
            patch_kind = PATCH_STACK_ONLY;
        end
        m_data_next = {{M_PAD_W{1'b0}}, overflow, patch_otype, patch_tag, found, !found};
        m_user_next = patch_kind;
    end

    always_comb
    begin
        count_next = count_reg;
        if (item_last_reg)
        begin
            count_next = '0;
        end
        else if (ctl.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.cancel)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (resolve_go)
                begin
                    state_next = accept ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (resolve_go)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
                m_data_reg  <= m_data_next;
                m_user_reg  <= m_user_next;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("pending count above table depth");

    // no new event while the compare step runs
    a_no_accept_in_look: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> !s_axis_tready)
        else $error("input accepted during compare");

    // an event is kept exactly when it patches nothing
    a_kept_vs_patch: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_data_reg[0] != m_data_reg[1]))
        else $error("kept and patch flags disagree");

    // overflow only on a full table and never with a patch
    a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[50]) |-> !m_data_reg[1])
        else $error("overflow reported with a patch");

    // an append mid-buffer grows the table by one
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.append && !item_last_reg) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not advance count");

endmodule
